### rtl/cigarp_pkg.sv
// Shared types, constants and helper functions of the CIGAR text parser.
// Depends on nothing; every other file of the block imports it.
package cigarp_pkg;

    // Field widths of a result beat.
    localparam int LEN_W  = 28;
    localparam int CODE_W = 4;
    localparam int SPAN_W = 32;
    localparam int KIND_W = 2;

    // Longest legal run length.
    localparam logic [LEN_W-1:0] MAX_RUN = 28'h0FFF_FFFF;

    // Output queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_M    = 8'h4D;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_N    = 8'h4E;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_X    = 8'h58;

    // Operation codes.
    localparam logic [CODE_W-1:0] OP_M  = 4'd0;
    localparam logic [CODE_W-1:0] OP_I  = 4'd1;
    localparam logic [CODE_W-1:0] OP_D  = 4'd2;
    localparam logic [CODE_W-1:0] OP_N  = 4'd3;
    localparam logic [CODE_W-1:0] OP_S  = 4'd4;
    localparam logic [CODE_W-1:0] OP_H  = 4'd5;
    localparam logic [CODE_W-1:0] OP_P  = 4'd6;
    localparam logic [CODE_W-1:0] OP_EQ = 4'd7;
    localparam logic [CODE_W-1:0] OP_X  = 4'd8;

    // Kind of a result beat.
    typedef enum logic [KIND_W-1:0] {
        KIND_OP  = 2'd0,
        KIND_OK  = 2'd1,
        KIND_BAD = 2'd2
    } t_kind;

    // One accepted character beat.
    typedef struct packed {
        logic [7:0] char_code;
        logic       char_valid;
        logic       end_of_string;
    } t_char_item;

    // One result beat.
    typedef struct packed {
        t_kind              kind;
        logic [LEN_W-1:0]   op_length;
        logic [CODE_W-1:0]  op_code;
        logic [SPAN_W-1:0]  ref_span;
        logic               run_last;
    } t_result;

    // Parser state carried from one character to the next.
    typedef struct packed {
        logic [LEN_W-1:0]  pending_length;
        logic              have_digits;
        logic              failed;
        logic              at_start;
        logic              star_seen;
        logic [SPAN_W-1:0] span_total;
    } t_parse_state;

    // Results produced by one character, handed to the output queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // Operator lookup result.
    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } t_op_hit;

    localparam t_parse_state STATE_RESET = '{
        pending_length: '0,
        have_digits:    1'b0,
        failed:         1'b0,
        at_start:       1'b1,
        star_seen:      1'b0,
        span_total:     '0
    };

    // Maps an operator letter to its code.
    function automatic t_op_hit op_of(input logic [7:0] c);
        t_op_hit r;
        r.hit  = 1'b1;
        r.code = OP_M;
        case (c)
            CH_M:    r.code = OP_M;
            CH_I:    r.code = OP_I;
            CH_D:    r.code = OP_D;
            CH_N:    r.code = OP_N;
            CH_S:    r.code = OP_S;
            CH_H:    r.code = OP_H;
            CH_P:    r.code = OP_P;
            CH_EQ:   r.code = OP_EQ;
            CH_X:    r.code = OP_X;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // True for operations that consume reference bases.
    function automatic logic consumes_ref(input logic [CODE_W-1:0] code);
        return (code == OP_M) || (code == OP_D) || (code == OP_N) ||
               (code == OP_EQ) || (code == OP_X);
    endfunction

endpackage

### rtl/cigarp_ifs.sv
// Valid/ready channel interfaces of the CIGAR text parser: characters in, results out.
// Depends on cigarp_pkg for field widths.
interface cigarp_char_if import cigarp_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       char_valid;
    logic       end_of_string;

    modport source (output valid, char_code, char_valid, end_of_string, input ready);
    modport sink   (input valid, char_code, char_valid, end_of_string, output ready);
endinterface

interface cigarp_res_if import cigarp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [LEN_W-1:0]  op_length;
    logic [CODE_W-1:0] op_code;
    logic [SPAN_W-1:0] ref_span;
    logic              run_last;

    modport source (output valid, result_kind, op_length, op_code, ref_span, run_last,
                    input ready);
    modport sink   (input valid, result_kind, op_length, op_code, ref_span, run_last,
                    output ready);
endinterface

### rtl/cigarp_core.sv
// Next-state and result logic for one character of a CIGAR string.
// Depends on cigarp_pkg; purely combinational, used by cigar_text_parser_unit.
module cigarp_core import cigarp_pkg::*; (
    input  logic         i_fire,
    input  t_char_item   i_item,
    input  t_parse_state i_state,
    output t_parse_state o_state,
    output t_push        o_push
);

    logic [SPAN_W-1:0] w_prod;
    logic              w_is_digit;
    t_op_hit           w_op;
    t_parse_state      w_st;
    t_result           w_op_res;
    t_result           w_end_res;
    logic              w_emit_op;

    // Run length times ten plus the new digit; fits in 32 bits for any legal length.
    assign w_prod = ({{(SPAN_W-LEN_W){1'b0}}, i_state.pending_length} << 3)
                  + ({{(SPAN_W-LEN_W){1'b0}}, i_state.pending_length} << 1)
                  + {{(SPAN_W-4){1'b0}}, i_item.char_code[3:0]};

    assign w_is_digit = (i_item.char_code >= CH_ZERO) && (i_item.char_code <= CH_NINE);
    assign w_op       = op_of(i_item.char_code);

    // Character handling, then end-of-string handling.
    always_comb begin
        w_st      = i_state;
        w_emit_op = 1'b0;
        w_op_res  = '{kind: KIND_OP, op_length: i_state.pending_length,
                      op_code: w_op.code, ref_span: '0, run_last: 1'b0};
        w_end_res = '{kind: KIND_OK, op_length: '0, op_code: '0,
                      ref_span: '0, run_last: 1'b1};

        if (i_item.char_valid && !i_state.failed) begin
            w_st.at_start = 1'b0;
            if (i_state.star_seen) begin
                w_st.failed = 1'b1;
            end else if (w_is_digit) begin
                if (w_prod > {{(SPAN_W-LEN_W){1'b0}}, MAX_RUN}) begin
                    w_st.failed = 1'b1;
                end else begin
                    w_st.pending_length = w_prod[LEN_W-1:0];
                    w_st.have_digits    = 1'b1;
                end
            end else if (i_item.char_code == CH_STAR && i_state.at_start) begin
                w_st.star_seen = 1'b1;
            end else if (!w_op.hit || !i_state.have_digits) begin
                w_st.failed = 1'b1;
            end else begin
                w_emit_op = 1'b1;
                if (consumes_ref(w_op.code)) begin
                    w_st.span_total = i_state.span_total
                                    + {{(SPAN_W-LEN_W){1'b0}}, i_state.pending_length};
                end
                w_st.pending_length = '0;
                w_st.have_digits    = 1'b0;
            end
        end else if (i_item.char_valid) begin
            w_st.at_start = 1'b0;
        end

        // Closing beat of the string.
        if (w_st.have_digits || w_st.failed) begin
            w_end_res.kind = KIND_BAD;
        end else begin
            w_end_res.ref_span = w_st.span_total;
        end

        o_state = i_state;
        o_push  = '{count: 2'd0, first: w_op_res, second: w_end_res};
        if (i_fire) begin
            o_state = i_item.end_of_string ? STATE_RESET : w_st;
            if (w_emit_op) begin
                o_push.count = i_item.end_of_string ? 2'd2 : 2'd1;
            end else if (i_item.end_of_string) begin
                o_push.count = 2'd1;
                o_push.first = w_end_res;
            end
        end
    end

endmodule

### rtl/cigarp_outq.sv
// Four-entry result queue: takes up to two result beats a cycle, sends at most one.
// Depends on cigarp_pkg and the result channel interface in cigarp_ifs.sv.
module cigarp_outq import cigarp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    cigarp_res_if.source o_res
);

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] w_wr_ptr1;
    logic              w_pop;
    t_result           w_head;

    assign w_wr_ptr1 = r_wr_ptr + 1'b1;
    assign w_pop     = o_res.valid && o_res.ready;

    // Room for two more beats regardless of what leaves this cycle.
    assign o_room = (r_count <= QCNT_W'(QDEPTH - 2));

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.count);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push.count) - QCNT_W'(w_pop);
        end
    end

    // Head of the queue drives the output channel.
    assign w_head            = r_mem[r_rd_ptr];
    assign o_res.valid       = (r_count != '0);
    assign o_res.result_kind = w_head.kind;
    assign o_res.op_length   = w_head.op_length;
    assign o_res.op_code     = w_head.op_code;
    assign o_res.ref_span    = w_head.ref_span;
    assign o_res.run_last    = w_head.run_last;

endmodule

### rtl/cigar_text_parser_unit.sv
// CIGAR text parser: takes one character beat per cycle and emits an operation
// beat (run length and code) for each operator letter, plus one closing beat per
// string with ok or malformed and, when ok, the reference span. Each accepted beat
// is held in an input register and parsed from there once the output queue has
// room, and its results are then written into that four-entry output queue, from
// whose head they are taken. The block sustains one character per cycle; an
// operator letter that also ends a string yields two result beats, and the input
// register holds whenever the queue has fewer than two free slots. On a malformed
// closing beat the operation beats already sent for that string are to be dropped.
// Depends on cigarp_pkg, cigarp_ifs.sv, cigarp_core and cigarp_outq.
module cigar_text_parser_unit import cigarp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cigarp_char_if.sink  i_char,
    cigarp_res_if.source o_res
);

    logic         r_item_vld;
    t_char_item   r_item;
    t_parse_state r_state;
    t_parse_state n_state;
    t_push        w_push;
    logic         w_room;
    logic         w_fire;
    logic         w_accept;

    // Parse the held beat when the queue can take both of its possible results.
    assign w_fire       = r_item_vld && w_room;
    assign i_char.ready = !r_item_vld || w_fire;
    assign w_accept     = i_char.valid && i_char.ready;

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else if (i_char.ready) begin
            r_item_vld <= i_char.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= '{char_code:     i_char.char_code,
                        char_valid:    i_char.char_valid,
                        end_of_string: i_char.end_of_string};
        end
    end

    // Parser state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    cigarp_core u_core (
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_push  (w_push)
    );

    cigarp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_res   (o_res)
    );

endmodule
